// File: design/pfe_pkg.sv
// shared constants, types and state encoding for the postfix expression evaluator
package pfe_pkg;

    // default sizes
    localparam int unsigned DEF_STACK_DEPTH = 16;
    localparam int unsigned DEF_DATA_WIDTH  = 32;

    // field widths fixed by the stream format
    localparam int unsigned SYM_W    = 8;
    localparam int unsigned STATUS_W = 3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOTAL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LONG    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FEW     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MANY    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd6;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd7;

    // expression characters
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_DONE
    } pfe_state_t;

    // request to the iterative multiply / divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } pfe_alu_req_t;

endpackage

// File: design/pfe_alu.sv
// iterative shift-add multiplier and restoring divider, one bit per cycle
module pfe_alu
    import pfe_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pfe_alu_req_t          req,
    input  logic [DATA_WIDTH-1:0] opa,
    input  logic [DATA_WIDTH-1:0] opb,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  div_reg, div_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;

    logic [DATA_WIDTH-1:0] mag_a, mag_b;
    logic [DATA_WIDTH:0]   rem_sh, diff;
    logic [DATA_WIDTH-1:0] acc_step, x_step, y_step, quot_out;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    // one step of either operation
    always_comb begin
        mag_a    = opa[DATA_WIDTH-1] ? (~opa + 1'b1) : opa;
        mag_b    = opb[DATA_WIDTH-1] ? (~opb + 1'b1) : opb;
        rem_sh   = {acc_reg, y_reg[DATA_WIDTH-1]};
        diff     = rem_sh - {1'b0, x_reg};
        if (div_reg) begin
            x_step = x_reg;
            if (!diff[DATA_WIDTH]) begin
                acc_step = diff[DATA_WIDTH-1:0];
                y_step   = {y_reg[DATA_WIDTH-2:0], 1'b1};
            end else begin
                acc_step = rem_sh[DATA_WIDTH-1:0];
                y_step   = {y_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end else begin
            acc_step = y_reg[0] ? (acc_reg + x_reg) : acc_reg;
            x_step   = {x_reg[DATA_WIDTH-2:0], 1'b0};
            y_step   = {1'b0, y_reg[DATA_WIDTH-1:1]};
        end
        quot_out = neg_reg ? (~y_step + 1'b1) : y_step;
    end

    // sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        if (busy_reg) begin
            x_next   = x_step;
            y_next   = y_step;
            acc_next = acc_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cnt_next  = '0;
                res_next  = div_reg ? quot_out : acc_step;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = '0;
            acc_next  = '0;
            neg_next  = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
            if (req.is_div) begin
                x_next = mag_b;
                y_next = mag_a;
            end else begin
                x_next = opa;
                y_next = opb;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: design/postfix_expression_evaluator.sv
// a digit or error goes from the idle to the done state, + or - passes through the read
// state, and * or / also through the wait state; one character at a time, * and / hold the
// block until the one-bit-per-cycle multiply / divide unit finishes
// operands below the top of stack live in a one-port-read memory with a registered read
// reset (aresetn low, synchronous) empties the stack and clears the latched error;
// stack memory contents are not cleared
module postfix_expression_evaluator
    import pfe_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int unsigned DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SYM_W-1:0]       s_tdata,   // [7:0] symbol
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] status, then value (DATA_WIDTH bits), zero padded to bytes
    output logic [((STATUS_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int unsigned OUT_W = ((STATUS_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int unsigned AW    = $clog2(STACK_DEPTH);
    localparam int unsigned CW    = $clog2(STACK_DEPTH + 1);

    // operand memory, entries below the top of stack
    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    pfe_state_t            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [STATUS_W-1:0]   err_reg, err_next;
    logic [DATA_WIDTH-1:0] tos_reg, tos_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic                  last_reg, last_next;
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [DATA_WIDTH-1:0] m_value_reg, m_value_next;
    logic                  m_last_reg, m_last_next;

    pfe_alu_req_t          alu_req;
    logic                  alu_done;
    logic [DATA_WIDTH-1:0] alu_result;

    logic                  in_xfer;
    logic                  is_digit, is_op;
    logic [DATA_WIDTH-1:0] top_val;

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tos_reg      <= tos_next;
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
    end

    pfe_alu #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_alu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (alu_req),
        .opa    (rd_data_reg),
        .opb    (tos_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    // input decode
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign is_op    = (s_tdata == CH_PLUS) || (s_tdata == CH_MINUS)
                   || (s_tdata == CH_STAR) || (s_tdata == CH_SLASH);
    assign top_val  = (count_reg != '0) ? tos_reg : '0;

    // sequencer: next state, stack update and result register
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        tos_next      = tos_reg;
        sym_next      = sym_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        mem_we        = 1'b0;
        mem_waddr     = AW'(count_reg - 1'b1);
        mem_wdata     = tos_reg;
        mem_re        = 1'b0;
        mem_raddr     = AW'(count_reg - CW'(2));
        alu_req       = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    sym_next   = s_tdata;
                    last_next  = s_tlast;
                    state_next = S_DONE;
                    if (err_reg != ST_OK) begin
                        // latched error: symbol ignored
                    end else if (is_digit) begin
                        if (count_reg == CW'(STACK_DEPTH)) begin
                            err_next = ST_LONG;
                        end else begin
                            // old top moves into memory
                            mem_we     = (count_reg != '0);
                            tos_next   = {{(DATA_WIDTH - 4){1'b0}}, s_tdata[3:0]};
                            count_next = count_reg + 1'b1;
                        end
                    end else if (is_op) begin
                        if (count_reg < CW'(2)) begin
                            err_next = ST_FEW;
                        end else if ((s_tdata == CH_SLASH) && (tos_reg == '0)) begin
                            err_next = ST_DIVZERO;
                        end else begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                    end else begin
                        err_next = ST_INVALID;
                    end
                end
            end
            S_READ: begin
                // left operand now in rd_data_reg, right operand is the top
                if (sym_reg == CH_PLUS) begin
                    tos_next   = rd_data_reg + tos_reg;
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end else if (sym_reg == CH_MINUS) begin
                    tos_next   = rd_data_reg - tos_reg;
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end else begin
                    alu_req.start  = 1'b1;
                    alu_req.is_div = (sym_reg == CH_SLASH);
                    state_next     = S_WAIT;
                end
            end
            S_WAIT: begin
                if (alu_done) begin
                    tos_next   = alu_result;
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // load the result once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_last_next  = last_reg;
                    state_next   = S_IDLE;
                    if (!last_reg) begin
                        m_status_next = err_reg;
                        m_value_next  = top_val;
                    end else begin
                        m_value_next = '0;
                        if (err_reg != ST_OK) begin
                            m_status_next = err_reg;
                        end else if (count_reg == '0) begin
                            m_status_next = ST_EMPTY;
                        end else if (count_reg == CW'(1)) begin
                            m_status_next = ST_TOTAL;
                            m_value_next  = tos_reg;
                        end else begin
                            m_status_next = ST_MANY;
                        end
                        count_next = '0;
                        err_next   = ST_OK;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_value_reg, m_status_reg});
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // stack occupancy never goes past STACK_DEPTH entries, top register included
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // the multiply / divide unit only finishes while the sequencer waits for it
    a_alu_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state_reg == S_WAIT))
        else $error("alu finished outside wait state");

    // a closing result empties the stack and clears the error
    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DONE) && last_reg && (!m_valid_reg || m_tready))
        |=> ((count_reg == '0) && (err_reg == ST_OK)))
        else $error("stack not cleared after closing transfer");

    // an operator only reaches the read state with two operands available
    a_read_operands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (count_reg >= CW'(2)))
        else $error("operand read with fewer than two entries");
`endif

endmodule

// File: bench/pfe_stream_checker.sv
// stream checker for the postfix expression evaluator: predicts each result and compares it
`timescale 1ns / 100ps

module pfe_stream_checker
    import pfe_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int unsigned DATA_WIDTH  = DEF_DATA_WIDTH,
    parameter int unsigned TDATA_W     = ((STATUS_W + DATA_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [SYM_W-1:0]   s_tdata,   // [7:0] symbol
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // [2:0] status, then value, zero padded
    input  logic               m_tlast,
    output int                 mismatch_count,
    output int                 outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [DATA_WIDTH-1:0] value;
        logic                  closes;
    } outcome_t;

    // results still owed by the block, oldest first
    outcome_t expected_outcomes[$];

    // shadow copy of the evaluator state
    logic [DATA_WIDTH-1:0] shadow_stack [STACK_DEPTH];
    int unsigned           shadow_depth;
    logic [STATUS_W-1:0]   shadow_error;

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, seen,
                 wanted);
        mismatch_count++;
    endtask

    // one operator on two words; returns 0 on division by zero
    function automatic bit apply_operator(input logic [SYM_W-1:0] op,
                                          input logic [DATA_WIDTH-1:0] lhs,
                                          input logic [DATA_WIDTH-1:0] rhs,
                                          output logic [DATA_WIDTH-1:0] res);
        logic [DATA_WIDTH-1:0] mag_l;
        logic [DATA_WIDTH-1:0] mag_r;
        logic [DATA_WIDTH-1:0] quo;
        mag_l = lhs[DATA_WIDTH-1] ? -lhs : lhs;
        mag_r = rhs[DATA_WIDTH-1] ? -rhs : rhs;
        res   = '0;
        case (op)
            CH_PLUS:  res = lhs + rhs;
            CH_MINUS: res = lhs - rhs;
            CH_STAR:  res = lhs * rhs;
            default: begin
                if (rhs == '0) return 1'b0;
                // unsigned magnitudes, so the most negative value wraps onto itself
                quo = mag_l / mag_r;
                res = (lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1]) ? -quo : quo;
            end
        endcase
        return 1'b1;
    endfunction

    // advance the shadow state by one symbol and give the result it causes
    function automatic outcome_t evaluate_symbol(input logic [SYM_W-1:0] sym,
                                                 input logic closing);
        outcome_t              res;
        logic [DATA_WIDTH-1:0] word;
        logic                  is_digit;
        logic                  is_op;
        res      = '0;
        is_digit = (sym >= CH_ZERO) && (sym <= CH_NINE);
        is_op    = (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_STAR) ||
                   (sym == CH_SLASH);
        // symbols after a latched error are ignored
        if (shadow_error == ST_OK) begin
            if (is_digit) begin
                if (shadow_depth >= STACK_DEPTH) begin
                    shadow_error = ST_LONG;
                end else begin
                    shadow_stack[shadow_depth] = DATA_WIDTH'(sym - CH_ZERO);
                    shadow_depth++;
                end
            end else if (is_op) begin
                if (shadow_depth < 2) begin
                    shadow_error = ST_FEW;
                end else if (!apply_operator(sym, shadow_stack[shadow_depth-2],
                                             shadow_stack[shadow_depth-1], word)) begin
                    shadow_error = ST_DIVZERO;
                end else begin
                    shadow_depth--;
                    shadow_stack[shadow_depth-1] = word;
                end
            end else begin
                shadow_error = ST_INVALID;
            end
        end
        res.closes = closing;
        if (!closing) begin
            res.status = shadow_error;
            if (shadow_depth > 0) res.value = shadow_stack[shadow_depth-1];
        end else begin
            // closing character: report the outcome, then empty the stack
            if (shadow_error != ST_OK) begin
                res.status = shadow_error;
            end else if (shadow_depth == 0) begin
                res.status = ST_EMPTY;
            end else if (shadow_depth == 1) begin
                res.status = ST_TOTAL;
                res.value  = shadow_stack[0];
            end else begin
                res.status = ST_MANY;
            end
            shadow_depth = 0;
            shadow_error = ST_OK;
        end
        return res;
    endfunction

    // watch both channels at the rising edge
    always @(posedge aclk) begin : watch
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            expected_outcomes.delete();
            shadow_depth   = 0;
            shadow_error   = ST_OK;
            mismatch_count = 0;
        end else begin
            // result transfer
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                got.status = m_tdata[STATUS_W-1:0];
                got.value  = m_tdata[STATUS_W +: DATA_WIDTH];
                got.closes = m_tlast;
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result transfer, status", got.status, '0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.value !== want.value)
                        report_mismatch("value", got.value, want.value);
                    if (got.closes !== want.closes)
                        report_mismatch("final flag", got.closes, want.closes);
                    if ((m_tdata >> (STATUS_W + DATA_WIDTH)) !== '0)
                        report_mismatch("padding", m_tdata >> (STATUS_W + DATA_WIDTH), '0);
                end
            end
            // symbol transfer
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
                expected_outcomes.push_back(evaluate_symbol(s_tdata, s_tlast));
        end
        outstanding = expected_outcomes.size();
    end

endmodule

// File: bench/postfix_expression_evaluator_tb.sv
// top of the postfix expression evaluator bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module postfix_expression_evaluator_tb
    import pfe_pkg::*;
();

    localparam int unsigned STACK_DEPTH  = DEF_STACK_DEPTH;
    localparam int unsigned DATA_WIDTH   = DEF_DATA_WIDTH;
    localparam int unsigned TDATA_W      = ((STATUS_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int          RANDOM_ITEMS = 1800;
    localparam int          HOLD_CYCLES  = 400;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [SYM_W-1:0]   s_tdata;   // [7:0] symbol
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // [2:0] status, then value, zero padded
    logic               m_tlast;

    int  mismatch_count;
    int  outstanding;
    int  symbols_sent = 0;
    bit  no_gaps      = 1'b0;
    bit  hold_request = 1'b0;

    // characters of the expression being built
    logic [SYM_W-1:0] expression_chars[$];

    always #4 aclk = ~aclk;

    postfix_expression_evaluator #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pfe_stream_checker #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .TDATA_W     (TDATA_W)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (no_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SYM_W-1:0] random_digit();
        return CH_ZERO + SYM_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [SYM_W-1:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // one symbol transfer, with an optional idle stretch in front
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic closing);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = sym;
        s_tlast  = closing;
        do @(posedge aclk); while (s_tready !== 1'b1);
        symbols_sent++;
    endtask

    task automatic add_text(input string text);
        for (int i = 0; i < text.len(); i++) expression_chars.push_back(text[i]);
    endtask

    // send the built expression, marking its final character
    task automatic issue_expression();
        for (int i = 0; i < expression_chars.size(); i++)
            send_symbol(expression_chars[i], i == expression_chars.size() - 1);
        expression_chars.delete();
    endtask

    // valid postfix with the given number of operators
    task automatic build_well_formed(input int n_ops);
        int digits_left;
        int ops_left;
        int depth;
        digits_left = n_ops + 1;
        ops_left    = n_ops;
        depth       = 0;
        while (digits_left + ops_left > 0) begin
            if (depth >= 2 && ops_left > 0 && (digits_left == 0 || $urandom_range(0, 1))) begin
                expression_chars.push_back(random_operator());
                ops_left--;
                depth--;
            end else begin
                expression_chars.push_back(random_digit());
                digits_left--;
                depth++;
            end
        end
    endtask

    // mix of good expressions, overflowing stacks, noise, broken sequences, leftover digits and the most negative value
    task automatic build_random_expression();
        int roll;
        int idx;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            build_well_formed($urandom_range(0, 10));
        end else if (roll < 73) begin
            // more digits than the stack holds
            repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4))
                expression_chars.push_back(random_digit());
            repeat ($urandom_range(0, 3)) expression_chars.push_back(random_operator());
        end else if (roll < 81) begin
            repeat ($urandom_range(1, 6))
                expression_chars.push_back(SYM_W'($urandom_range(0, 255)));
        end else if (roll < 89) begin
            build_well_formed($urandom_range(1, 8));
            if ($urandom_range(0, 1)) begin
                idx = $urandom_range(0, expression_chars.size() - 1);
                expression_chars[idx] = SYM_W'($urandom_range(0, 255));
            end else begin
                expression_chars.push_front(random_operator());
            end
        end else if (roll < 95) begin
            repeat ($urandom_range(2, 5)) expression_chars.push_back(random_digit());
        end else if (roll < 98) begin
            // doubling up to the most negative value, then divide by minus one or a lone operator
            add_text("2");
            repeat (DATA_WIDTH - 2) add_text("2*");
            if ($urandom_range(0, 1)) add_text("01-/");
            else expression_chars.push_back(random_operator());
        end else begin
            build_well_formed(STACK_DEPTH - 1);
        end
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(posedge aclk);
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : result_sink
        int stall_left;
        bit hold_taken;
        stall_left = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready   = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int  random_start;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed expressions
        add_text("9");     issue_expression();
        add_text("34+");   issue_expression();
        add_text("35-");   issue_expression();
        add_text("99*");   issue_expression();
        add_text("07-3/"); issue_expression();
        add_text("50/");   issue_expression();
        add_text("+");     issue_expression();
        add_text("1");
        expression_chars.push_back(8'hFF);
        issue_expression();
        // characters after an error are ignored
        add_text("1");
        expression_chars.push_back(8'h00);
        add_text("2");
        issue_expression();
        add_text("12");    issue_expression();

        // sender stops until every result is back
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait_drained();

        // random expressions
        random_start = symbols_sent;
        while (symbols_sent - random_start < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if (!hold_done && symbols_sent - random_start >= RANDOM_ITEMS / 3) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && symbols_sent - random_start >= 2 * RANDOM_ITEMS / 3) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                wait_drained();
                pause_done = 1'b1;
            end
            build_random_expression();
            issue_expression();
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait_drained();
        repeat (2 * DATA_WIDTH) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #12_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
